// ===== hw/rtl/rre_pkg.sv =====
// ---------------------------------------------------------------------------
// rre_pkg
// Shared sizes, codes and controller/datapath interface types of the
// regret ratio evaluator.
// ---------------------------------------------------------------------------
package rre_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_DIMS   = 8;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int DIM_W      = $clog2(MAX_DIMS);
    localparam int NP_W       = 11;
    localparam int ND_W       = 4;
    localparam int CFG_W      = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int VAL_W      = 16;
    localparam int W_W        = 17;
    localparam int PROD_W     = 34;
    localparam int SCORE_W    = 19;
    localparam int Q16_W      = 17;
    localparam int SUM_W      = 33;
    localparam int CNT_W      = 16;
    localparam int DVD_W      = 35;

    localparam logic [VAL_W-1:0] VAL_ONE   = 16'h8000;
    localparam logic [Q16_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_MARK   = 2'd1,
        FUNC_WEIGHT = 2'd2,
        FUNC_REPORT = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_POINTS = 3'd0,
        CFG_NUM_DIMS   = 3'd1,
        CFG_SPLIT_DIM  = 3'd2,
        CFG_LIB_MODE   = 3'd3,
        CFG_FLOOR_M    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic coord_wr;
        logic member_wr;
        logic weight_wr;
        logic clr_wr;
        logic scan_init;
        logic scan_issue;
        logic ratio_go;
        logic stats_upd;
        logic avg_go;
        logic emit;
        logic emit_report;
    } rre_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic pipe_idle;
        logic div_done;
    } rre_stat_t;

endpackage

// ===== hw/rtl/rre_ram.sv =====
// ---------------------------------------------------------------------------
// rre_ram
// Generic single-port RAM, registered read.
// ---------------------------------------------------------------------------
module rre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/rre_divider.sv =====
// ---------------------------------------------------------------------------
// rre_divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rre_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [rre_pkg::DVD_W-1:0] dividend,
    input  logic [rre_pkg::SCORE_W-1:0] divisor,
    output logic [rre_pkg::DVD_W-1:0] quotient,
    output logic                      done
);
    import rre_pkg::*;

    localparam int CNT_BITS = $clog2(DVD_W + 1);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DVD_W - 1);

    logic                  run_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [SCORE_W:0]      rem_reg;
    logic [DVD_W-1:0]      dvd_reg;
    logic [DVD_W-1:0]      q_reg;
    logic [SCORE_W-1:0]    dsr_reg;
    logic [SCORE_W:0]      rem_sh;
    logic                  fits;

    assign rem_sh = {rem_reg[SCORE_W-1:0], dvd_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            q_reg   <= {q_reg[DVD_W-2:0], fits};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ===== hw/rtl/rre_datapath.sv =====
// ---------------------------------------------------------------------------
// rre_datapath
// Point store lanes, subset RAM, weights, scan pipeline, divider and
// statistics registers.
// ---------------------------------------------------------------------------
module rre_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rre_pkg::rre_cmd_t             cmd,
    output rre_pkg::rre_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [rre_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rre_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [rre_pkg::PT_W-1:0]      point_index,
    input  logic [rre_pkg::DIM_W-1:0]     dim_index,
    input  logic [rre_pkg::VAL_W-1:0]     value,
    output logic                          done,
    output logic                          is_report,
    output logic [rre_pkg::Q16_W-1:0]     trial_regret,
    output logic [rre_pkg::Q16_W-1:0]     max_regret,
    output logic [rre_pkg::Q16_W-1:0]     average_regret,
    output logic [rre_pkg::CNT_W-1:0]     trials_done,
    output logic                          zero_regret
);
    import rre_pkg::*;

    // configuration
    logic [NP_W-1:0]    num_points_reg;
    logic [ND_W-1:0]    num_dims_reg;
    logic [ND_W-1:0]    split_dim_reg;
    logic               lib_mode_reg;
    logic [SCORE_W-1:0] floor_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NP_W'(MAX_POINTS);
            num_dims_reg   <= ND_W'(MAX_DIMS);
            split_dim_reg  <= ND_W'(MAX_DIMS);
            lib_mode_reg   <= 1'b0;
            floor_m_reg    <= SCORE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_NUM_POINTS: num_points_reg <= cfg_wdata[NP_W-1:0];
                CFG_NUM_DIMS:   num_dims_reg   <= cfg_wdata[ND_W-1:0];
                CFG_SPLIT_DIM:  split_dim_reg  <= cfg_wdata[ND_W-1:0];
                CFG_LIB_MODE:   lib_mode_reg   <= cfg_wdata[0];
                CFG_FLOOR_M:    floor_m_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [NP_W-1:0] np;
    logic [ND_W-1:0] nd;
    logic [SCORE_W-1:0] fl;
    assign np = (num_points_reg > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : num_points_reg;
    assign nd = (num_dims_reg > ND_W'(MAX_DIMS)) ? ND_W'(MAX_DIMS) : num_dims_reg;
    assign fl = (floor_m_reg == '0) ? SCORE_W'(1) : floor_m_reg;

    logic [VAL_W-1:0] val_sat;
    assign val_sat = (value > VAL_ONE) ? VAL_ONE : value;

    // weights
    logic signed [W_W-1:0] weight_reg [MAX_DIMS];
    logic                  neg;
    assign neg = lib_mode_reg && ({1'b0, dim_index} >= split_dim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                weight_reg[d] <= '0;
            end
        end
        else if (cmd.weight_wr)
        begin
            weight_reg[dim_index] <= neg ? -$signed({1'b0, val_sat})
                                         : $signed({1'b0, val_sat});
        end
    end

    // shared index for clearing pass and scan
    logic [NP_W-1:0] idx_reg;
    logic            rd_valid;
    assign rd_valid = cmd.scan_issue && (idx_reg < np);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            idx_reg <= '0;
        end
        else if (cmd.clr_wr || rd_valid)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign stat.clr_last = idx_reg[PT_W-1:0] == PT_W'(MAX_POINTS - 1);
    assign stat.scan_end = idx_reg >= np;

    logic [PT_W-1:0] ram_addr;
    assign ram_addr = (cmd.coord_wr || cmd.member_wr) ? point_index : idx_reg[PT_W-1:0];

    logic [VAL_W-1:0] coord [MAX_DIMS];
    logic             member;

    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_lane
        rre_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_coord (
            .clk   (clk),
            .we    (cmd.coord_wr && (dim_index == DIM_W'(d))),
            .addr  (ram_addr),
            .wdata (val_sat),
            .rdata (coord[d])
        );
    end

    rre_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_member (
        .clk   (clk),
        .we    (cmd.member_wr || cmd.clr_wr),
        .addr  (ram_addr),
        .wdata (cmd.member_wr),
        .rdata (member)
    );

    // scan pipeline
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     m2_reg, m3_reg;
    logic signed [PROD_W-1:0] prod_reg [MAX_DIMS];
    logic signed [PROD_W+1:0] psum_reg [2];
    logic signed [PROD_W+1:0] psum [2];
    logic signed [PROD_W+2:0] total;
    logic [SCORE_W-1:0]       score;
    logic [SCORE_W-1:0]       best_all_reg, best_sub_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= rd_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign stat.pipe_idle = !(v1_reg || v2_reg || v3_reg);

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            psum[h] = '0;
            for (int k = 0; k < MAX_DIMS / 2; k++)
            begin
                psum[h] = psum[h] + (PROD_W+2)'(prod_reg[h * (MAX_DIMS / 2) + k]);
            end
        end
        total = (PROD_W+3)'(psum_reg[0]) + (PROD_W+3)'(psum_reg[1]);
        score = (total <= 0) ? '0 : total[SCORE_W+14:15];
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            prod_reg[d] <= (ND_W'(d) < nd) ? $signed({1'b0, coord[d]}) * weight_reg[d]
                                           : $signed(PROD_W'(0));
        end
        m2_reg      <= member;
        m3_reg      <= m2_reg;
        psum_reg[0] <= psum[0];
        psum_reg[1] <= psum[1];
        if (cmd.scan_init)
        begin
            best_all_reg <= '0;
            best_sub_reg <= '0;
        end
        else if (v3_reg)
        begin
            if (score > best_all_reg)
            begin
                best_all_reg <= score;
            end
            if (m3_reg && (score > best_sub_reg))
            begin
                best_sub_reg <= score;
            end
        end
    end

    // statistics state
    logic [Q16_W-1:0] regret_reg;
    logic [Q16_W-1:0] max_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [Q16_W-1:0] regret_now;

    // divider
    logic [SCORE_W-1:0] fl_sub, fl_all;
    logic [DVD_W-1:0]   dividend;
    logic [SCORE_W-1:0] divisor;
    logic [DVD_W-1:0]   quotient;
    logic [Q16_W-1:0]   q_cap;

    assign fl_sub   = (best_sub_reg < fl) ? fl : best_sub_reg;
    assign fl_all   = (best_all_reg < fl) ? fl : best_all_reg;
    assign dividend = cmd.avg_go ? DVD_W'(sum_reg) : {fl_sub, 16'h0000};
    assign divisor  = cmd.avg_go ? SCORE_W'(cnt_reg) : fl_all;
    assign q_cap    = (quotient > DVD_W'(ONE_Q16)) ? ONE_Q16 : quotient[Q16_W-1:0];

    rre_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.ratio_go || cmd.avg_go),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (stat.div_done)
    );

    // statistics
    assign regret_now = ONE_Q16 - q_cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.stats_upd)
        begin
            if (regret_now > max_reg)
            begin
                max_reg <= regret_now;
            end
            if (cnt_reg != COUNT_MAX)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'(regret_now);
            end
        end
        else if (cmd.emit && cmd.emit_report)
        begin
            max_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.stats_upd)
        begin
            regret_reg <= regret_now;
        end
    end

    // result register
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            is_report      <= cmd.emit_report;
            trial_regret   <= cmd.emit_report ? '0 : regret_reg;
            max_regret     <= max_reg;
            average_regret <= (cnt_reg == '0) ? '0 : q_cap;
            trials_done    <= cnt_reg;
            zero_regret    <= max_reg == '0;
        end
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/rre_ctrl.sv =====
// ---------------------------------------------------------------------------
// rre_ctrl
// Sequencer: clearing pass, request decode, scan, divides and result.
// ---------------------------------------------------------------------------
module rre_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         func,
    input  logic               last_element,
    input  rre_pkg::rre_stat_t stat,
    output rre_pkg::rre_cmd_t  cmd,
    output logic               busy
);
    import rre_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR      = 10'b00_0000_0001,
        S_IDLE       = 10'b00_0000_0010,
        S_SCAN       = 10'b00_0000_0100,
        S_DRAIN      = 10'b00_0000_1000,
        S_RATIO_GO   = 10'b00_0001_0000,
        S_RATIO_WAIT = 10'b00_0010_0000,
        S_UPDATE     = 10'b00_0100_0000,
        S_AVG_GO     = 10'b00_1000_0000,
        S_AVG_WAIT   = 10'b01_0000_0000,
        S_EMIT       = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   report_reg, report_next;
    logic   accept;
    func_t  f;

    assign accept = start && (state_reg == S_IDLE);
    assign f      = func_t'(func);
    assign busy   = state_reg != S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        cmd         = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (f)
                        FUNC_LOAD:   cmd.coord_wr  = 1'b1;
                        FUNC_MARK:   cmd.member_wr = 1'b1;
                        FUNC_WEIGHT:
                        begin
                            cmd.weight_wr = 1'b1;
                            if (last_element)
                            begin
                                cmd.scan_init = 1'b1;
                                report_next   = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        FUNC_REPORT:
                        begin
                            report_next = 1'b1;
                            state_next  = S_AVG_GO;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_idle)
                begin
                    state_next = S_RATIO_GO;
                end
            end
            S_RATIO_GO:
            begin
                cmd.ratio_go = 1'b1;
                state_next   = S_RATIO_WAIT;
            end
            S_RATIO_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.stats_upd = 1'b1;
                state_next    = S_AVG_GO;
            end
            S_AVG_GO:
            begin
                cmd.avg_go = 1'b1;
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_report = report_reg;
                state_next      = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/regret_ratio_evaluator_core.sv =====
// ---------------------------------------------------------------------------
// regret_ratio_evaluator_core
// Maximum regret ratio evaluator over sampled utility weight vectors.
// ---------------------------------------------------------------------------
// After reset the block is busy while the subset RAM is cleared. Load,
// mark and non-final weight requests are taken without leaving the idle
// state. A final weight element starts a trial: the point store is scanned
// one point per cycle through eight parallel lanes, then the ratio and the
// running average are each computed in a shared bit-serial divider. A
// report runs only the average divide.
// The result appears for one cycle with done high; it cannot be held off,
// so the receiver must take it when it arrives.
module regret_ratio_evaluator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_we,
    input  logic [rre_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rre_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [1:0]                    func,
    input  logic [rre_pkg::PT_W-1:0]      point_index,
    input  logic [rre_pkg::DIM_W-1:0]     dim_index,
    input  logic [rre_pkg::VAL_W-1:0]     value,
    input  logic                          last_element,
    output logic                          done,
    output logic                          is_report,
    output logic [rre_pkg::Q16_W-1:0]     trial_regret,
    output logic [rre_pkg::Q16_W-1:0]     max_regret,
    output logic [rre_pkg::Q16_W-1:0]     average_regret,
    output logic [rre_pkg::CNT_W-1:0]     trials_done,
    output logic                          zero_regret
);
    import rre_pkg::*;

    rre_cmd_t  cmd;
    rre_stat_t stat;

    rre_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .last_element (last_element),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy)
    );

    rre_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .point_index    (point_index),
        .dim_index      (dim_index),
        .value          (value),
        .done           (done),
        .is_report      (is_report),
        .trial_regret   (trial_regret),
        .max_regret     (max_regret),
        .average_regret (average_regret),
        .trials_done    (trials_done),
        .zero_regret    (zero_regret)
    );

endmodule

// ===== hw/rtl/rre_checker.sv =====
// ---------------------------------------------------------------------------
// rre_checker
// Port-level checks of the regret ratio evaluator, bound to the top level.
// ---------------------------------------------------------------------------
module rre_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    func,
    input logic                          done,
    input logic                          is_report,
    input logic [rre_pkg::Q16_W-1:0]     trial_regret,
    input logic [rre_pkg::Q16_W-1:0]     max_regret,
    input logic [rre_pkg::Q16_W-1:0]     average_regret
);
    import rre_pkg::*;

    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_REPORT) |=> busy)
        else $error("report request did not start work");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

    a_report_regret: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_report) |-> trial_regret == '0)
        else $error("report carries a trial regret");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (trial_regret <= max_regret || is_report) && average_regret <= ONE_Q16)
        else $error("regret beyond bounds");

endmodule

bind regret_ratio_evaluator_core rre_checker u_rre_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .done           (done),
    .is_report      (is_report),
    .trial_regret   (trial_regret),
    .max_regret     (max_regret),
    .average_regret (average_regret)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Regret ratio evaluator testbench
// Loads point coordinates, marks subset members and sends utility weight
// vectors under a range of register settings. A scoreboard predicts every
// trial result and report and compares it field by field with the outputs.
// ---------------------------------------------------------------------------
module testbench;

    import rre_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        bit        is_rep;
        bit [16:0] regret;
        bit [16:0] max_r;
        bit [16:0] avg_r;
        bit [15:0] count;
        bit        zero_r;
    } regret_result_t;

    typedef struct {
        int unsigned np;
        int unsigned nd;
        int unsigned split;
        int unsigned lib;
        int unsigned flr;
    } regret_setting_t;

    class regret_scoreboard;
        bit [15:0]        coord [MAX_POINTS][MAX_DIMS];
        bit               member [MAX_POINTS];
        int               weight [MAX_DIMS];
        bit [16:0]        max_r;
        bit [32:0]        sum_r;
        bit [15:0]        count;
        int unsigned      np, nd, split, lib, flr;
        int               errors;
        regret_result_t   pending [$];

        function new();
            np = 1024;
            nd = 8;
            split = 8;
            lib = 0;
            flr = 1;
            errors = 0;
            max_r = 0;
            sum_r = 0;
            count = 0;
            foreach (member[i]) member[i] = 0;
            foreach (weight[i]) weight[i] = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, bit [18:0] d);
            case (idx)
                CFG_NUM_POINTS: np = d[10:0];
                CFG_NUM_DIMS:   nd = d[3:0];
                CFG_SPLIT_DIM:  split = d[3:0];
                CFG_LIB_MODE:   lib = d[0];
                CFG_FLOOR_M:    flr = d;
                default: ;
            endcase
        endfunction

        function bit [16:0] average_now();
            longint unsigned a;
            if (count == 0)
                return 0;
            a = sum_r / count;
            return (a > 65536) ? 17'h10000 : a[16:0];
        endfunction

        function bit [16:0] trial_regret_of();
            int unsigned     np_e, nd_e, fl, s, best_sub, best_all;
            longint          acc;
            longint unsigned ratio;
            np_e = (np > MAX_POINTS) ? MAX_POINTS : np;
            nd_e = (nd > MAX_DIMS) ? MAX_DIMS : nd;
            fl = (flr == 0) ? 1 : flr;
            best_sub = 0;
            best_all = 0;
            for (int i = 0; i < np_e; i++)
            begin
                acc = 0;
                for (int d = 0; d < nd_e; d++)
                    acc += longint'(coord[i][d]) * longint'(weight[d]);
                s = (acc <= 0) ? 0 : int'(acc >> 15);
                if (s > best_all)
                    best_all = s;
                if (member[i] && s > best_sub)
                    best_sub = s;
            end
            if (best_sub < fl)
                best_sub = fl;
            if (best_all < fl)
                best_all = fl;
            ratio = (longint'(best_sub) * 65536) / best_all;
            if (ratio > 65536)
                ratio = 65536;
            return 17'(65536 - ratio);
        endfunction

        function void push(bit is_rep, bit [16:0] r);
            regret_result_t e;
            e.is_rep = is_rep;
            e.regret = r;
            e.max_r  = max_r;
            e.avg_r  = average_now();
            e.count  = count;
            e.zero_r = (max_r == 0);
            pending.push_back(e);
        endfunction

        function void note_request(func_t f, bit [9:0] pt, bit [2:0] dim,
                                   bit [15:0] v, bit last);
            bit [16:0] r;
            if (v > 16'h8000)
                v = 16'h8000;
            case (f)
                FUNC_LOAD:   coord[pt][dim] = v;
                FUNC_MARK:   member[pt] = 1;
                FUNC_WEIGHT:
                begin
                    weight[dim] = (lib == 1 && dim >= split) ? -int'(v) : int'(v);
                    if (last)
                    begin
                        r = trial_regret_of();
                        if (r > max_r)
                            max_r = r;
                        if (count != 16'hFFFF)
                        begin
                            count++;
                            sum_r = sum_r + r;
                        end
                        push(0, r);
                    end
                end
                default:
                begin
                    push(1, 0);
                    max_r = 0;
                    sum_r = 0;
                    count = 0;
                end
            endcase
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(regret_result_t got);
            regret_result_t e;
            if (pending.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.is_rep !== e.is_rep)
                report($sformatf("is_report %0d, expected %0d", got.is_rep, e.is_rep));
            if (got.regret !== e.regret)
                report($sformatf("trial_regret %0d, expected %0d", got.regret, e.regret));
            if (got.max_r !== e.max_r)
                report($sformatf("max_regret %0d, expected %0d", got.max_r, e.max_r));
            if (got.avg_r !== e.avg_r)
                report($sformatf("average_regret %0d, expected %0d", got.avg_r, e.avg_r));
            if (got.count !== e.count)
                report($sformatf("trials_done %0d, expected %0d", got.count, e.count));
            if (got.zero_r !== e.zero_r)
                report($sformatf("zero_regret %0d, expected %0d", got.zero_r, e.zero_r));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic [1:0]           func;
    logic [PT_W-1:0]      point_index;
    logic [DIM_W-1:0]     dim_index;
    logic [VAL_W-1:0]     value;
    logic                 last_element;
    logic                 done;
    logic                 is_report;
    logic [Q16_W-1:0]     trial_regret;
    logic [Q16_W-1:0]     max_regret;
    logic [Q16_W-1:0]     average_regret;
    logic [CNT_W-1:0]     trials_done;
    logic                 zero_regret;

    regret_scoreboard sb;
    bit               written [MAX_POINTS][MAX_DIMS];
    bit               no_gaps;
    int               idle_cycles;

    regret_ratio_evaluator_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .func           (func),
        .point_index    (point_index),
        .dim_index      (dim_index),
        .value          (value),
        .last_element   (last_element),
        .done           (done),
        .is_report      (is_report),
        .trial_regret   (trial_regret),
        .max_regret     (max_regret),
        .average_regret (average_regret),
        .trials_done    (trials_done),
        .zero_regret    (zero_regret)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        regret_result_t got;
        if (done === 1'b1)
        begin
            got.is_rep = is_report;
            got.regret = trial_regret;
            got.max_r  = max_regret;
            got.avg_r  = average_regret;
            got.count  = trials_done;
            got.zero_r = zero_regret;
            sb.check_result(got);
        end
        if (done === 1'b1 || (start && busy === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task send_request(func_t f, bit [9:0] pt, bit [2:0] dim, bit [15:0] v, bit last);
        int gap;
        func         <= f;
        point_index  <= pt;
        dim_index    <= dim;
        value        <= v;
        last_element <= last;
        start        <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_request(f, pt, dim, v, last);
        if (f == FUNC_LOAD)
            written[pt][dim] = 1;
        if (no_gaps)
            gap = 0;
        else if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(10, 40);
        else
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task apply_setting(regret_setting_t s);
        bit [18:0] vals [5];
        vals = '{19'(s.np), 19'(s.nd), 19'(s.split), 19'(s.lib), 19'(s.flr)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= cfg_idx_t'(i);
            cfg_wdata <= vals[i];
            sb.set_reg(cfg_idx_t'(i), vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function bit [15:0] rand_value();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 32768));
    endfunction

    task fill_scan_range();
        int unsigned np_e, nd_e;
        np_e = (sb.np > MAX_POINTS) ? MAX_POINTS : sb.np;
        nd_e = (sb.nd > MAX_DIMS) ? MAX_DIMS : sb.nd;
        for (int p = 0; p < np_e; p++)
            for (int d = 0; d < nd_e; d++)
                if (!written[p][d])
                    send_request(FUNC_LOAD, p, d, rand_value(), $urandom_range(0, 1));
    endtask

    task random_requests(int n);
        int unsigned np_e, sel;
        bit [9:0]    pt;
        np_e = (sb.np > MAX_POINTS) ? MAX_POINTS : sb.np;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            if (np_e > 0 && $urandom_range(0, 4) != 0)
                pt = $urandom_range(0, np_e - 1);
            else
                pt = $urandom_range(0, MAX_POINTS - 1);
            if (sel < 35)
                send_request(FUNC_LOAD, pt, $urandom_range(0, 7), rand_value(),
                             $urandom_range(0, 1));
            else if (sel < 47)
                send_request(FUNC_MARK, pt, $urandom_range(0, 7), rand_value(),
                             $urandom_range(0, 1));
            else if (sel < 95)
                send_request(FUNC_WEIGHT, pt, $urandom_range(0, 7), rand_value(),
                             $urandom_range(0, 9) < 4);
            else
                send_request(FUNC_REPORT, pt, $urandom_range(0, 7), rand_value(),
                             $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        regret_setting_t settings [8];
        settings[0] = '{16, 8, 8, 0, 1};
        settings[1] = '{16, 8, 3, 1, 1};
        settings[2] = '{0, 5, 0, 1, 0};
        settings[3] = '{17, 0, 15, 1, 524287};
        settings[4] = '{1, 1, 0, 0, 100};
        settings[5] = '{24, 15, 4, 1, 32768};
        settings[6] = '{20, 1, 0, 1, 1};
        settings[7] = '{24, 1, 8, 0, 262144};

        sb = new();
        idle_cycles = 0;
        no_gaps = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        func = '0;
        point_index = '0;
        dim_index = '0;
        value = '0;
        last_element = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);

        // directed: reports on empty stats, saturating values, stray last flags
        apply_setting(settings[0]);
        send_request(FUNC_REPORT, 0, 0, 0, 1);
        send_request(FUNC_LOAD, 1023, 7, 16'hFFFF, 1);
        send_request(FUNC_LOAD, 0, 0, 16'h8001, 0);
        send_request(FUNC_MARK, 1023, 7, 16'hFFFF, 1);
        send_request(FUNC_MARK, 0, 0, 0, 0);
        fill_scan_range();
        send_request(FUNC_LOAD, 1, 0, 16'h0000, 0);
        send_request(FUNC_LOAD, 2, 0, 16'h8000, 0);
        send_request(FUNC_WEIGHT, 0, 7, 0, 1);
        for (int d = 0; d < 8; d++)
            send_request(FUNC_WEIGHT, 0, d, 16'h8000, d == 7);
        send_request(FUNC_MARK, 2, 0, 0, 0);
        send_request(FUNC_WEIGHT, 0, 0, 16'hFFFF, 1);
        send_request(FUNC_WEIGHT, 0, 3, 16'h7FFF, 0);
        send_request(FUNC_REPORT, 0, 0, 16'hFFFF, 0);
        send_request(FUNC_REPORT, 0, 0, 0, 0);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                apply_setting(settings[ph]);
                fill_scan_range();
            end
            no_gaps = ($urandom_range(0, 2) == 0);
            random_requests(ph >= 6 ? 30 : 48);
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rre_pkg.sv
hw/rtl/rre_ram.sv
hw/rtl/rre_divider.sv
hw/rtl/rre_datapath.sv
hw/rtl/rre_ctrl.sv
hw/rtl/regret_ratio_evaluator_core.sv
hw/rtl/rre_checker.sv
tb/testbench.sv
